@@ hw/rtl/sha256_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam int unsigned BUF_WORDS = 16;
   localparam int unsigned HASH_WORDS = 8;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LAST_POS = 6'h3F;
   localparam logic [5:0] LEN_POS = 6'd56;
   localparam logic [6:0] FULL_FILL = 7'd64;
   localparam logic [2:0] LAST_INDEX = 3'd7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_PAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // control from the sequencer to the compression engine
   typedef struct packed {
      logic start;
      logic init;
   } core_ctrl_type;

   typedef struct packed {
      logic done;
   } core_stat_type;

   // how the block being compressed is formed from buffer and padding
   typedef struct packed {
      logic [6:0] fill;
      logic       mark;
      logic       len_en;
   } blk_type;

   typedef logic [HASH_WORDS-1:0][31:0] hash_type;

   localparam hash_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                          input logic [31:0] g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

@@ hw/rtl/sha256_buf.sv @@
// Block buffer memory with byte writes and padded word readout.
module sha256_buf
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        wr_en,
   input  logic [5:0]  wr_pos,
   input  logic [7:0]  wr_data,
   input  logic [3:0]  rd_addr,
   input  blk_type     blk,
   input  logic [63:0] bit_count,
   output logic [31:0] rd_word
);

   logic [3:0][7:0] buffer_mem_ff [BUF_WORDS];
   logic [3:0][7:0] rd_data_ff;
   logic [3:0]      rd_idx_ff;
   logic [31:0]     len_word;

   // byte 0 of a word is its most significant byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         buffer_mem_ff[wr_pos[5:2]][~wr_pos[1:0]] <= wr_data;
      end
      rd_data_ff <= buffer_mem_ff[rd_addr];
      rd_idx_ff <= rd_addr;
   end

   assign len_word = rd_idx_ff[0] ? bit_count[31:0] : bit_count[63:32];

   // bytes below the fill come from the buffer, then the mark, zeros and the length
   always_comb begin
      logic [6:0] pos;
      rd_word = '0;
      for (int lane = 0; lane < 4; lane++) begin
         pos = {1'b0, rd_idx_ff, 2'(lane)};
         if (pos < blk.fill) begin
            rd_word[31-8*lane -: 8] = rd_data_ff[2'(3 - lane)];
         end else if (blk.mark && pos == blk.fill) begin
            rd_word[31-8*lane -: 8] = PAD_MARK;
         end else if (blk.len_en && rd_idx_ff[3:1] == 3'b111) begin
            rd_word[31-8*lane -: 8] = len_word[31-8*lane -: 8];
         end else begin
            rd_word[31-8*lane -: 8] = 8'h00;
         end
      end
   end

endmodule

@@ hw/rtl/sha256_core.sv @@
// Compression engine: one round per cycle, schedule shift line and hash registers.
module sha256_core
   import sha256_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  core_ctrl_type ctrl,
   input  logic [31:0]   w_in,
   output logic [3:0]    rd_addr,
   output core_stat_type stat,
   output hash_type      hash
);

   logic [31:0] v_ff [HASH_WORDS];
   logic [31:0] v_in [HASH_WORDS];
   logic [31:0] sched_ff [BUF_WORDS];
   logic [31:0] w_cur;
   logic [31:0] t1;
   logic [31:0] t2;
   logic [5:0]  rnd_ff;
   logic [5:0]  rnd_in;
   logic        run_ff;
   logic        run_in;
   logic        fin_ff;
   logic        fin_in;
   hash_type    hash_ff;
   hash_type    hash_in;

   // fetch the next buffer word in the cycle before its round
   assign rd_addr = (run_ff && rnd_ff < 6'd15) ? rnd_ff[3:0] + 4'd1 : 4'd0;

   assign stat.done = fin_ff;
   assign hash = hash_ff;

   always_comb begin
      if (rnd_ff[5:4] == 2'b00) begin
         w_cur = w_in;
      end else begin
         w_cur = small_sigma1(sched_ff[14]) + sched_ff[9] + small_sigma0(sched_ff[1])
               + sched_ff[0];
      end
      t1 = v_ff[7] + big_sigma1(v_ff[4]) + choose(v_ff[4], v_ff[5], v_ff[6])
         + ROUND_K[rnd_ff] + w_cur;
      t2 = big_sigma0(v_ff[0]) + majority(v_ff[0], v_ff[1], v_ff[2]);
   end

   always_comb begin
      v_in = v_ff;
      rnd_in = rnd_ff;
      run_in = run_ff;
      fin_in = 1'b0;
      hash_in = hash_ff;
      if (ctrl.start) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            v_in[i] = hash_ff[i];
         end
         rnd_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         v_in[0] = t1 + t2;
         v_in[1] = v_ff[0];
         v_in[2] = v_ff[1];
         v_in[3] = v_ff[2];
         v_in[4] = v_ff[3] + t1;
         v_in[5] = v_ff[4];
         v_in[6] = v_ff[5];
         v_in[7] = v_ff[6];
         rnd_in = rnd_ff + 6'd1;
         if (rnd_ff == LAST_POS) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
      if (ctrl.init) begin
         hash_in = INIT_HASH;
      end else if (fin_ff) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            hash_in[i] = hash_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
         rnd_ff <= '0;
         hash_ff <= INIT_HASH;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
         rnd_ff <= rnd_in;
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      if (run_ff) begin
         for (int i = 0; i < BUF_WORDS - 1; i++) begin
            sched_ff[i] <= sched_ff[i+1];
         end
         sched_ff[BUF_WORDS-1] <= w_cur;
      end
   end

endmodule

@@ hw/rtl/sha256_stream_hasher.sv @@
// SHA-256 stream hasher top level: sequencer, bit counter and result register.
// Absorb: the 64th byte of a block starts the 64 rounds and the hash update;
// input stalls while the block is compressed.
// Finish: digest items follow the padded block and, where needed, an extra length block,
// then one per cycle while the result side takes them; input stalls until all are issued.
// Synchronous reset restores the initial hash value and clears the bit count.
module sha256_stream_hasher
   import sha256_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type     state_ff;
   state_type     state_in;
   logic [63:0]   bit_count_ff;
   logic [63:0]   bit_count_in;
   blk_type       blk_ff;
   blk_type       blk_in;
   logic          pad2_ff;
   logic          pad2_in;
   logic          final_ff;
   logic          final_in;
   logic [2:0]    idx_ff;
   logic [2:0]    idx_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_data_ff;
   rsp_type       rsp_data_in;
   logic          accept;
   logic          load_rsp;
   logic          wr_en;
   logic [5:0]    pos;
   logic [3:0]    rd_addr;
   logic [31:0]   rd_word;
   core_ctrl_type ctrl;
   core_stat_type stat;
   hash_type      hash;

   assign pos = bit_count_ff[8:3];
   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign load_rsp = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.command == CMD_FINISH || pos == LAST_POS)) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (stat.done) begin
               if (pad2_ff) begin
                  state_in = ST_PAD;
               end else if (final_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PAD: begin
            state_in = ST_BUSY;
         end
         ST_EMIT: begin
            if (load_rsp && idx_ff == LAST_INDEX) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      bit_count_in = bit_count_ff;
      blk_in = blk_ff;
      pad2_in = pad2_ff;
      final_in = final_ff;
      idx_in = idx_ff;
      wr_en = 1'b0;
      ctrl = '0;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.command == CMD_FINISH) begin
                  // mark after the last byte; length goes here or in an extra block
                  blk_in.fill = {1'b0, pos};
                  blk_in.mark = 1'b1;
                  blk_in.len_en = (pos < LEN_POS);
                  pad2_in = (pos >= LEN_POS);
                  final_in = 1'b1;
                  ctrl.start = 1'b1;
               end else begin
                  wr_en = 1'b1;
                  bit_count_in = bit_count_ff + 64'd8;
                  if (pos == LAST_POS) begin
                     blk_in.fill = FULL_FILL;
                     blk_in.mark = 1'b0;
                     blk_in.len_en = 1'b0;
                     pad2_in = 1'b0;
                     final_in = 1'b0;
                     ctrl.start = 1'b1;
                  end
               end
            end
         end
         ST_BUSY: begin
            idx_in = '0;
         end
         ST_PAD: begin
            blk_in.fill = '0;
            blk_in.mark = 1'b0;
            blk_in.len_en = 1'b1;
            pad2_in = 1'b0;
            ctrl.start = 1'b1;
         end
         ST_EMIT: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.digest_word = hash[idx_ff];
               rsp_data_in.word_index = idx_ff;
               rsp_data_in.last_word = (idx_ff == LAST_INDEX);
               idx_in = idx_ff + 3'd1;
               if (idx_ff == LAST_INDEX) begin
                  // start a new message
                  ctrl.init = 1'b1;
                  bit_count_in = '0;
                  final_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bit_count_ff <= '0;
         pad2_ff <= 1'b0;
         final_ff <= 1'b0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bit_count_ff <= bit_count_in;
         pad2_ff <= pad2_in;
         final_ff <= final_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      rsp_data_ff <= rsp_data_in;
   end

   sha256_buf u_buf (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_pos    (pos),
      .wr_data   (req_data.data_byte),
      .rd_addr   (rd_addr),
      .blk       (blk_ff),
      .bit_count (bit_count_ff),
      .rd_word   (rd_word)
   );

   sha256_core u_core (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .w_in    (rd_word),
      .rd_addr (rd_addr),
      .stat    (stat),
      .hash    (hash)
   );

endmodule

@@ hw/rtl/sha256_checker.sv @@
// Port-level checks for the SHA-256 stream hasher and their binding.
module sha256_checker
   import sha256_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.last_word == (rsp_data.word_index == LAST_INDEX))
      else $error("last_word disagrees with word_index");

   a_word_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_word |=>
         rsp_valid && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1)
      else $error("digest words out of order or gapped");

   a_digest_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last_word |=> !rsp_valid)
      else $error("result item after the final digest word");

   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("digest issued while input side was open");

endmodule

bind sha256_stream_hasher sha256_checker u_checker (.*);
